### design/spoly_pkg.sv
// shared widths, request, operation and status codes and saturation limits of the sparse polynomial unit
package spoly_pkg;

  localparam int REQ_W  = 3;
  localparam int COEF_W = 32;
  localparam int EXPI_W = 9;
  localparam int OP_W   = 2;
  localparam int EXPO_W = 10;
  localparam int STAT_W = 2;

  localparam logic [REQ_W-1:0] REQ_LOAD_A  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR   = 3'd4;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  localparam logic signed [47:0] Q_MAX = 48'sh0000_7FFF_FFFF;
  localparam logic signed [47:0] Q_MIN = -48'sh0000_8000_0000;
  localparam logic signed [32:0] S_MAX = 33'sh0_7FFF_FFFF;
  localparam logic signed [32:0] S_MIN = -33'sh0_8000_0000;

endpackage

### design/sparse_polynomial_add_sub_mul.sv
// sparse polynomial add, subtract and multiply unit with a dense accumulator memory
//
// channel  dir  handshake               payload
// in       in   in_valid / in_ready     in_req_type, in_coef_in, in_exp_in, in_op_sel
// out      out  out_valid / out_ready   out_coef_out, out_exp_out, out_term_valid,
//                                       out_last_term, out_sat, out_status
//
// one request in flight at a time; every request gives exactly one result beat
// load and clear: execute, then finish; compute: a clearing sweep of all 2^(EXP_BITS+1)
//   accumulator entries, then a select, issue, fetch and accumulate step per term (add,
//   subtract) or per term pair (multiply, with an extra select step at each new B term),
//   the fetch and accumulate steps doing the read-modify-write of the accumulator memory
// read: a scan of the accumulator entries from the read pointer, up to 2^(EXP_BITS+1)
// synchronous active-low reset clears control; memories are not reset
// a result beat that is not taken holds the next request in its final state
module sparse_polynomial_add_sub_mul #(
  parameter int MAX_TERMS = 16,
  parameter int EXP_BITS  = 9
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [spoly_pkg::REQ_W-1:0]       in_req_type,
  input  logic signed [spoly_pkg::COEF_W-1:0] in_coef_in,
  input  logic [spoly_pkg::EXPI_W-1:0]      in_exp_in,
  input  logic [spoly_pkg::OP_W-1:0]        in_op_sel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [spoly_pkg::COEF_W-1:0] out_coef_out,
  output logic [spoly_pkg::EXPO_W-1:0]      out_exp_out,
  output logic                              out_term_valid,
  output logic                              out_last_term,
  output logic                              out_sat,
  output logic [spoly_pkg::STAT_W-1:0]      out_status
);
  import spoly_pkg::*;

  localparam int AW    = EXP_BITS + 1;
  localparam int DEPTH = 1 << AW;
  localparam int TW    = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW    = $clog2(MAX_TERMS + 1);
  localparam int WW    = COEF_W + EXP_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_EXEC  = 4'd1;
  localparam logic [3:0] S_CLR   = 4'd2;
  localparam logic [3:0] S_SEL   = 4'd3;
  localparam logic [3:0] S_ISSUE = 4'd4;
  localparam logic [3:0] S_FETCH = 4'd5;
  localparam logic [3:0] S_ACCUM = 4'd6;
  localparam logic [3:0] S_SCAN1 = 4'd7;
  localparam logic [3:0] S_SCAN2 = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  // term stores and accumulator
  logic [WW-1:0]         ta_mem [MAX_TERMS];
  logic [WW-1:0]         tb_mem [MAX_TERMS];
  logic [COEF_W-1:0]     acc_mem [DEPTH];
  logic [WW-1:0]         ta_q, tb_q;
  logic [COEF_W-1:0]     acc_q;

  logic                  ta_we, tb_we, acc_we;
  logic [WW-1:0]         t_wdata;
  logic [AW-1:0]         acc_waddr, acc_raddr;
  logic [COEF_W-1:0]     acc_wdata;

  // control
  logic [3:0]            st_r, st_nxt;
  logic [REQ_W-1:0]      req_r, req_nxt;
  logic [COEF_W-1:0]     coef_r, coef_nxt;
  logic [EXP_BITS-1:0]   exp_r, exp_nxt;
  logic [OP_W-1:0]       op_r, op_nxt;
  logic [CW-1:0]         cnt_a_r, cnt_a_nxt, cnt_b_r, cnt_b_nxt;
  logic [CW-1:0]         i_r, i_nxt, j_r, j_nxt;
  logic                  phase_r, phase_nxt;
  logic [AW-1:0]         rp_r, rp_nxt;
  logic                  rdy_r, rdy_nxt;
  logic                  sat_r, sat_nxt;
  logic [AW:0]           ptr_r, ptr_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         e_r, e_nxt;
  logic [COEF_W-1:0]     ecoef_r, ecoef_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic signed [63:0]    prod_r, prod_nxt;

  // pending result and output beat
  logic [COEF_W-1:0]     res_coef_r, res_coef_nxt;
  logic [AW-1:0]         res_exp_r, res_exp_nxt;
  logic                  res_tv_r, res_tv_nxt, res_last_r, res_last_nxt;
  logic [STAT_W-1:0]     res_st_r, res_st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COEF_W-1:0]     out_coef_r, out_coef_nxt;
  logic [EXPO_W-1:0]     out_exp_r, out_exp_nxt;
  logic                  out_tv_r, out_tv_nxt, out_last_r, out_last_nxt, out_sat_r, out_sat_nxt;
  logic [STAT_W-1:0]     out_st_r, out_st_nxt;

  // datapath temporaries
  logic signed [COEF_W-1:0] a_coef, b_coef;
  logic [EXP_BITS-1:0]   a_exp, b_exp;
  logic signed [32:0]    c33;
  logic signed [47:0]    q48;
  logic signed [31:0]    q32;
  logic signed [32:0]    s33;
  logic                  q_sat, s_sat;
  logic                  hit, none;
  logic [AW-1:0]         hit_addr;

  assign a_coef   = signed'(ta_q[EXP_BITS +: COEF_W]);
  assign b_coef   = signed'(tb_q[EXP_BITS +: COEF_W]);
  assign a_exp    = ta_q[EXP_BITS-1:0];
  assign b_exp    = tb_q[EXP_BITS-1:0];
  assign hit      = pend_r && (acc_q != '0);
  assign none     = !pend_r && ptr_r[AW];
  assign hit_addr = AW'(ptr_r - (AW+1)'(1));

  // accumulate stage: floor shift, clamp to 32 bits, saturating add
  always_comb begin
    q48   = prod_r[63:16];
    q_sat = 1'b0;
    if (q48 > Q_MAX) begin
      q32   = Q_MAX[31:0];
      q_sat = 1'b1;
    end else if (q48 < Q_MIN) begin
      q32   = Q_MIN[31:0];
      q_sat = 1'b1;
    end else begin
      q32 = q48[31:0];
    end
    s33   = 33'(signed'(acc_q)) + 33'(q32);
    s_sat = (s33 > S_MAX) || (s33 < S_MIN);
  end

  always_comb begin
    st_nxt        = st_r;
    req_nxt       = req_r;
    coef_nxt      = coef_r;
    exp_nxt       = exp_r;
    op_nxt        = op_r;
    cnt_a_nxt     = cnt_a_r;
    cnt_b_nxt     = cnt_b_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    phase_nxt     = phase_r;
    rp_nxt        = rp_r;
    rdy_nxt       = rdy_r;
    sat_nxt       = sat_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    e_nxt         = e_r;
    ecoef_nxt     = ecoef_r;
    idx_nxt       = idx_r;
    prod_nxt      = prod_r;
    res_coef_nxt  = res_coef_r;
    res_exp_nxt   = res_exp_r;
    res_tv_nxt    = res_tv_r;
    res_last_nxt  = res_last_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_coef_nxt  = out_coef_r;
    out_exp_nxt   = out_exp_r;
    out_tv_nxt    = out_tv_r;
    out_last_nxt  = out_last_r;
    out_sat_nxt   = out_sat_r;
    out_st_nxt    = out_st_r;
    ta_we         = 1'b0;
    tb_we         = 1'b0;
    t_wdata       = {coef_r, exp_r};
    acc_we        = 1'b0;
    acc_waddr     = idx_r;
    acc_wdata     = '0;
    acc_raddr     = ptr_r[AW-1:0];
    c33           = '0;
    in_ready      = (st_r == S_IDLE);

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt      = in_req_type;
          coef_nxt     = in_coef_in;
          exp_nxt      = EXP_BITS'(in_exp_in);
          op_nxt       = in_op_sel;
          res_coef_nxt = '0;
          res_exp_nxt  = '0;
          res_tv_nxt   = 1'b0;
          res_last_nxt = 1'b0;
          res_st_nxt   = STAT_OK;
          st_nxt       = S_EXEC;
        end
      end
      S_EXEC: begin
        st_nxt = S_FIN;
        case (req_r)
          REQ_LOAD_A: begin
            if (cnt_a_r == CW'(MAX_TERMS)) res_st_nxt = STAT_FULL;
            else begin
              ta_we     = 1'b1;
              cnt_a_nxt = cnt_a_r + CW'(1);
            end
          end
          REQ_LOAD_B: begin
            if (cnt_b_r == CW'(MAX_TERMS)) res_st_nxt = STAT_FULL;
            else begin
              tb_we     = 1'b1;
              cnt_b_nxt = cnt_b_r + CW'(1);
            end
          end
          REQ_COMPUTE: begin
            sat_nxt = 1'b0;
            ptr_nxt = '0;
            st_nxt  = S_CLR;
          end
          REQ_READ: begin
            if (!rdy_r) res_st_nxt = STAT_EMPTY;
            else begin
              ptr_nxt  = {1'b0, rp_r};
              pend_nxt = 1'b0;
              st_nxt   = S_SCAN1;
            end
          end
          REQ_CLEAR: begin
            cnt_a_nxt = '0;
            cnt_b_nxt = '0;
            rp_nxt    = '0;
            rdy_nxt   = 1'b0;
            sat_nxt   = 1'b0;
          end
          default: ;
        endcase
      end
      // zero the whole accumulator before summing
      S_CLR: begin
        acc_we    = 1'b1;
        acc_waddr = ptr_r[AW-1:0];
        ptr_nxt   = ptr_r + (AW+1)'(1);
        if (ptr_r[AW-1:0] == AW'(DEPTH - 1)) begin
          i_nxt     = '0;
          j_nxt     = '0;
          phase_nxt = 1'b0;
          st_nxt    = S_SEL;
        end
      end
      // pick the next term or term pair
      S_SEL: begin
        if (op_r == OP_ADD || op_r == OP_SUB) begin
          if (!phase_r) begin
            if (i_r < cnt_a_r) st_nxt = S_ISSUE;
            else phase_nxt = 1'b1;
          end else if (j_r < cnt_b_r) begin
            st_nxt = S_ISSUE;
          end else begin
            st_nxt = S_FIN;
          end
        end else if (op_r == OP_MUL) begin
          if (j_r >= cnt_b_r || cnt_a_r == '0) st_nxt = S_FIN;
          else if (i_r >= cnt_a_r) begin
            i_nxt = '0;
            j_nxt = j_r + CW'(1);
          end else begin
            st_nxt = S_ISSUE;
          end
        end else begin
          st_nxt = S_FIN;
        end
        if (st_nxt == S_FIN) begin
          rp_nxt  = '0;
          rdy_nxt = 1'b1;
        end
      end
      S_ISSUE: st_nxt = S_FETCH;
      S_FETCH: begin
        if (op_r == OP_MUL) begin
          prod_nxt = 64'(a_coef) * 64'(b_coef);
          idx_nxt  = AW'(a_exp) + AW'(b_exp);
        end else begin
          c33 = phase_r ? 33'(b_coef) : 33'(a_coef);
          if (phase_r && op_r == OP_SUB) c33 = -c33;
          prod_nxt = {{15{c33[32]}}, c33, 16'b0};
          idx_nxt  = phase_r ? AW'(b_exp) : AW'(a_exp);
        end
        acc_raddr = idx_nxt;
        st_nxt    = S_ACCUM;
      end
      S_ACCUM: begin
        acc_we = 1'b1;
        if (s33 > S_MAX) acc_wdata = S_MAX[31:0];
        else if (s33 < S_MIN) acc_wdata = S_MIN[31:0];
        else acc_wdata = s33[31:0];
        sat_nxt = sat_r | q_sat | s_sat;
        if (op_r == OP_MUL || !phase_r) i_nxt = i_r + CW'(1);
        else j_nxt = j_r + CW'(1);
        st_nxt = S_SEL;
      end
      // look for the next nonzero entry
      S_SCAN1: begin
        if (hit) begin
          e_nxt     = hit_addr;
          ecoef_nxt = acc_q;
          ptr_nxt   = {1'b0, hit_addr} + (AW+1)'(1);
          pend_nxt  = 1'b0;
          st_nxt    = S_SCAN2;
        end else if (none) begin
          if (rp_r == '0) begin
            res_tv_nxt   = 1'b1;
            res_last_nxt = 1'b1;
          end else begin
            res_st_nxt = STAT_EMPTY;
          end
          rdy_nxt = 1'b0;
          rp_nxt  = '0;
          st_nxt  = S_FIN;
        end else if (!ptr_r[AW]) begin
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + (AW+1)'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end
      // look past the found term to learn whether it is the last one
      S_SCAN2: begin
        res_coef_nxt = ecoef_r;
        res_exp_nxt  = e_r;
        if (hit) begin
          res_tv_nxt = 1'b1;
          rp_nxt     = hit_addr;
          st_nxt     = S_FIN;
        end else if (none) begin
          res_tv_nxt   = 1'b1;
          res_last_nxt = 1'b1;
          rdy_nxt      = 1'b0;
          rp_nxt       = '0;
          st_nxt       = S_FIN;
        end else if (!ptr_r[AW]) begin
          pend_nxt = 1'b1;
          ptr_nxt  = ptr_r + (AW+1)'(1);
        end else begin
          pend_nxt = 1'b0;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_coef_nxt  = res_coef_r;
          out_exp_nxt   = EXPO_W'(res_exp_r);
          out_tv_nxt    = res_tv_r;
          out_last_nxt  = res_last_r;
          out_sat_nxt   = sat_r;
          out_st_nxt    = res_st_r;
          st_nxt        = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ta_we) ta_mem[cnt_a_r[TW-1:0]] <= t_wdata;
    if (tb_we) tb_mem[cnt_b_r[TW-1:0]] <= t_wdata;
    ta_q <= ta_mem[i_r[TW-1:0]];
    tb_q <= tb_mem[j_r[TW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    acc_q <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      rp_r        <= '0;
      rdy_r       <= 1'b0;
      sat_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      cnt_a_r     <= cnt_a_nxt;
      cnt_b_r     <= cnt_b_nxt;
      rp_r        <= rp_nxt;
      rdy_r       <= rdy_nxt;
      sat_r       <= sat_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    coef_r     <= coef_nxt;
    exp_r      <= exp_nxt;
    op_r       <= op_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    phase_r    <= phase_nxt;
    ptr_r      <= ptr_nxt;
    e_r        <= e_nxt;
    ecoef_r    <= ecoef_nxt;
    idx_r      <= idx_nxt;
    prod_r     <= prod_nxt;
    res_coef_r <= res_coef_nxt;
    res_exp_r  <= res_exp_nxt;
    res_tv_r   <= res_tv_nxt;
    res_last_r <= res_last_nxt;
    res_st_r   <= res_st_nxt;
    out_coef_r <= out_coef_nxt;
    out_exp_r  <= out_exp_nxt;
    out_tv_r   <= out_tv_nxt;
    out_last_r <= out_last_nxt;
    out_sat_r  <= out_sat_nxt;
    out_st_r   <= out_st_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_coef_out   = signed'(out_coef_r);
  assign out_exp_out    = out_exp_r;
  assign out_term_valid = out_tv_r;
  assign out_last_term  = out_last_r;
  assign out_sat        = out_sat_r;
  assign out_status     = out_st_r;

`ifndef SYNTHESIS
  a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN1 || st_r == S_SCAN2) |-> !acc_we)
    else $error("accumulator written during a read scan");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (st_r == S_EXEC && !in_ready))
    else $error("accepted beat not dispatched");

  a_term_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_term_valid) |-> (out_status == STAT_OK))
    else $error("result term with error status");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_a_r <= CW'(MAX_TERMS)) && (cnt_b_r <= CW'(MAX_TERMS)))
    else $error("term count beyond store depth");
`endif

endmodule

### test/tb_sparse_polynomial_add_sub_mul.sv
// testbench for the sparse polynomial add, subtract and multiply unit
module tb_sparse_polynomial_add_sub_mul;
  timeunit 1ns;
  timeprecision 1ps;
  import spoly_pkg::*;

  localparam int NTERMS   = 16;
  localparam int EBITS    = 9;
  localparam int ACC_N    = 1 << (EBITS + 1);
  localparam int LIMIT    = 6_000_000;
  localparam int PHASE_N  = 340;
  localparam logic [REQ_W-1:0] REQ_NOP5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_NOP7 = 3'd7;
  localparam logic [OP_W-1:0]  OP_NONE  = 2'd3;
  localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] C_ONE = 32'sh0001_0000;

  // one result beat as the unit should produce it
  typedef struct packed {
    logic signed [COEF_W-1:0] coef;
    logic [EXPO_W-1:0]        expo;
    logic                     tvalid;
    logic                     last;
    logic                     sat;
    logic [STAT_W-1:0]        status;
  } term_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [REQ_W-1:0] in_req_type = '0;
  logic signed [COEF_W-1:0] in_coef_in = '0;
  logic [EXPI_W-1:0] in_exp_in = '0;
  logic [OP_W-1:0] in_op_sel = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COEF_W-1:0] out_coef_out;
  logic [EXPO_W-1:0] out_exp_out;
  logic out_term_valid, out_last_term, out_sat;
  logic [STAT_W-1:0] out_status;

  sparse_polynomial_add_sub_mul u_top (.*);

  always #4 clk = ~clk;

  // predictor state
  logic signed [31:0] poly_a_coef [NTERMS];
  logic [EBITS-1:0]   poly_a_exp  [NTERMS];
  logic signed [31:0] poly_b_coef [NTERMS];
  logic [EBITS-1:0]   poly_b_exp  [NTERMS];
  int                 n_a, n_b;
  logic signed [31:0] acc_mem [ACC_N];
  int                 scan_ptr;
  bit                 terms_pending;
  bit                 sat_flag;

  term_beat_t pending_terms[$];
  int errors, beats_seen, terms_read, sat_beats, full_beats, items_sent, cycles;
  int tx_idle, rx_idle, hold_left;

  // clamp to 32 bits, noting saturation
  function automatic logic signed [31:0] clamp_q(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat_flag = 1;
      return C_MAX;
    end
    if (v < -64'sd2147483648) begin
      sat_flag = 1;
      return C_MIN;
    end
    return v[31:0];
  endfunction

  function automatic void acc_add(input int e, input logic signed [63:0] c);
    acc_mem[e] = clamp_q(64'(acc_mem[e]) + c);
  endfunction

  function automatic void run_compute(input logic [OP_W-1:0] op);
    logic signed [63:0] p;
    logic signed [63:0] c;
    for (int k = 0; k < ACC_N; k++) acc_mem[k] = '0;
    sat_flag = 0;
    if (op == OP_ADD || op == OP_SUB) begin
      for (int i = 0; i < n_a; i++) acc_add(poly_a_exp[i], poly_a_coef[i]);
      for (int j = 0; j < n_b; j++) begin
        c = poly_b_coef[j];
        if (op == OP_SUB) c = clamp_q(-c);
        acc_add(poly_b_exp[j], c);
      end
    end else if (op == OP_MUL) begin
      for (int j = 0; j < n_b; j++)
        for (int i = 0; i < n_a; i++) begin
          p = 64'(poly_a_coef[i]) * 64'(poly_b_coef[j]);
          // arithmetic shift floors, matching truncation toward minus infinity
          acc_add(int'(poly_a_exp[i]) + int'(poly_b_exp[j]), clamp_q(p >>> 16));
        end
    end
    scan_ptr = 0;
    terms_pending = 1;
  endfunction

  // next-state and expected beat for one accepted request
  function automatic term_beat_t predict_term(input logic [REQ_W-1:0] req,
      input logic signed [31:0] coef, input logic [EXPI_W-1:0] ex,
      input logic [OP_W-1:0] op);
    term_beat_t r;
    int e, k;
    r = '0;
    case (req)
      REQ_LOAD_A: begin
        if (n_a >= NTERMS) r.status = STAT_FULL;
        else begin
          poly_a_coef[n_a] = coef;
          poly_a_exp[n_a] = ex;
          n_a++;
        end
      end
      REQ_LOAD_B: begin
        if (n_b >= NTERMS) r.status = STAT_FULL;
        else begin
          poly_b_coef[n_b] = coef;
          poly_b_exp[n_b] = ex;
          n_b++;
        end
      end
      REQ_COMPUTE: run_compute(op);
      REQ_READ: begin
        if (!terms_pending) r.status = STAT_EMPTY;
        else begin
          e = scan_ptr;
          while (e < ACC_N && acc_mem[e] == 0) e++;
          if (e < ACC_N) begin
            k = e + 1;
            while (k < ACC_N && acc_mem[k] == 0) k++;
            r.coef = acc_mem[e];
            r.expo = EXPO_W'(e);
            r.tvalid = 1;
            r.last = (k >= ACC_N);
            scan_ptr = (e + 1) % ACC_N;
            if (r.last) begin
              terms_pending = 0;
              scan_ptr = 0;
            end
          end else if (scan_ptr == 0) begin
            // everything cancelled: a single zero term at exponent zero
            r.tvalid = 1;
            r.last = 1;
            terms_pending = 0;
          end else begin
            r.status = STAT_EMPTY;
            terms_pending = 0;
            scan_ptr = 0;
          end
        end
      end
      REQ_CLEAR: begin
        n_a = 0;
        n_b = 0;
        for (int m = 0; m < ACC_N; m++) acc_mem[m] = '0;
        scan_ptr = 0;
        terms_pending = 0;
        sat_flag = 0;
      end
      default: ;
    endcase
    r.sat = sat_flag;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch beat %0d %s: got %0d expected %0d", beats_seen, what, got, want);
  endtask

  // send one request beat; valid stays high into the next call unless it idles
  task automatic send_req(input logic [REQ_W-1:0] req, input logic signed [31:0] coef,
      input logic [EXPI_W-1:0] ex, input logic [OP_W-1:0] op);
    if ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_coef_in <= coef;
    in_exp_in <= ex;
    in_op_sel <= op;
    do @(posedge clk); while (!in_ready);
    pending_terms.push_back(predict_term(req, coef, ex, op));
    items_sent++;
  endtask

  // receiver: random stalls plus a long hold-off set by the backpressure test
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // check every result beat against the oldest prediction
  always @(posedge clk) begin
    term_beat_t w;
    if (rst_n && out_valid && out_ready) begin
      beats_seen++;
      if (pending_terms.size() == 0) begin
        errors++;
        $display("unexpected result beat %0d", beats_seen);
      end else begin
        w = pending_terms.pop_front();
        if (out_coef_out !== w.coef) report("coef", out_coef_out, w.coef);
        if (out_exp_out !== w.expo) report("exp", out_exp_out, w.expo);
        if (out_term_valid !== w.tvalid) report("term_valid", out_term_valid, w.tvalid);
        if (out_last_term !== w.last) report("last_term", out_last_term, w.last);
        if (out_sat !== w.sat) report("sat", out_sat, w.sat);
        if (out_status !== w.status) report("status", out_status, w.status);
        if (w.tvalid) terms_read++;
        if (w.sat) sat_beats++;
        if (w.status == STAT_FULL) full_beats++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_sparse_polynomial_add_sub_mul NOT OK");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? C_MAX : C_MIN;
      2: return 32'(int'($urandom_range(8)) - 4) <<< 16;
      3: return 32'(int'($urandom_range(2000)) - 1000) <<< 12;
      default: return 32'(int'($urandom_range(200000)) - 100000);
    endcase
  endfunction

  function automatic logic [EXPI_W-1:0] rand_exp();
    case ($urandom_range(3))
      0: return EXPI_W'($urandom);
      1: return $urandom_range(1) ? 9'd511 : 9'd0;
      default: return EXPI_W'($urandom_range(12));
    endcase
  endfunction

  // directed corners: extremes, every request, every special case
  task automatic test_directed();
    send_req(REQ_READ, 0, 0, OP_ADD);           // nothing to read after reset
    send_req(REQ_LOAD_A, C_MAX, 9'd511, OP_ADD);
    send_req(REQ_LOAD_A, C_MIN, 9'd0, OP_ADD);
    send_req(REQ_LOAD_A, C_ONE, 9'd3, OP_ADD);
    send_req(REQ_LOAD_B, C_MIN, 9'd0, OP_ADD);
    send_req(REQ_LOAD_B, C_MAX, 9'd511, OP_ADD);
    send_req(REQ_COMPUTE, 0, 0, OP_SUB);        // negate most negative saturates
    repeat (4) send_req(REQ_READ, 0, 0, OP_ADD);
    send_req(REQ_COMPUTE, 0, 0, OP_MUL);        // product saturation, exponent 1022
    send_req(REQ_LOAD_A, -1, 9'd7, OP_ADD);     // load after compute keeps result
    repeat (3) send_req(REQ_READ, 0, 0, OP_ADD);
    send_req(REQ_COMPUTE, 0, 0, OP_NONE);       // unknown operation
    repeat (2) send_req(REQ_READ, 0, 0, OP_ADD);
    send_req(REQ_NOP5, 32'h1234_5678, 9'd5, OP_ADD);
    send_req(REQ_NOP7, -1, 9'd511, OP_NONE);
    send_req(REQ_CLEAR, 0, 0, OP_ADD);
    send_req(REQ_LOAD_A, C_ONE, 9'd5, OP_ADD);
    send_req(REQ_LOAD_B, C_ONE, 9'd5, OP_ADD);
    send_req(REQ_COMPUTE, 0, 0, OP_SUB);        // all cancelled
    send_req(REQ_READ, 0, 0, OP_ADD);
    send_req(REQ_CLEAR, 0, 0, OP_ADD);
    send_req(REQ_READ, 0, 0, OP_ADD);           // read after clear
  endtask

  // well-formed load, compute, read sequences with some noise
  task automatic test_random(input int n_items);
    int start, na, nb;
    logic [OP_W-1:0] op;
    bit mirror;
    start = items_sent;
    while (items_sent - start < n_items) begin
      if ($urandom_range(3) == 0)
        send_req(REQ_CLEAR, $urandom, EXPI_W'($urandom), OP_W'($urandom));
      na = ($urandom_range(9) == 0) ? $urandom_range(17, 14) : $urandom_range(5);
      nb = ($urandom_range(9) == 0) ? $urandom_range(17, 14) : $urandom_range(5);
      mirror = ($urandom_range(4) == 0);
      for (int i = 0; i < na; i++)
        send_req(REQ_LOAD_A, rand_coef(), rand_exp(), OP_W'($urandom));
      if (mirror) begin
        // replay the A store into B so a difference cancels
        for (int i = 0; i < n_a && i < nb + n_a; i++)
          if (n_b < NTERMS)
            send_req(REQ_LOAD_B, poly_a_coef[i], poly_a_exp[i], OP_W'($urandom));
      end else begin
        for (int i = 0; i < nb; i++)
          send_req(REQ_LOAD_B, rand_coef(), rand_exp(), OP_W'($urandom));
      end
      op = mirror ? OP_SUB : (($urandom_range(15) == 0) ? OP_NONE : OP_W'($urandom_range(2)));
      send_req(REQ_COMPUTE, $urandom, EXPI_W'($urandom), op);
      while (terms_pending) send_req(REQ_READ, $urandom, EXPI_W'($urandom), OP_W'($urandom));
      if ($urandom_range(2) == 0)
        send_req(REQ_READ, $urandom, EXPI_W'($urandom), OP_W'($urandom));
      if ($urandom_range(4) == 0)
        send_req(REQ_W'($urandom), $urandom, EXPI_W'($urandom), OP_W'($urandom));
    end
  endtask

  // long receiver hold-off while the sender keeps offering
  task automatic test_backpressure();
    int saved;
    saved = tx_idle;
    tx_idle = 0;
    hold_left = 400;
    send_req(REQ_CLEAR, 0, 0, OP_ADD);
    send_req(REQ_LOAD_A, C_ONE, 9'd2, OP_ADD);
    send_req(REQ_LOAD_B, -C_ONE, 9'd4, OP_ADD);
    send_req(REQ_COMPUTE, 0, 0, OP_MUL);
    repeat (2) send_req(REQ_READ, 0, 0, OP_ADD);
    tx_idle = saved;
  endtask

  initial begin
    int guard;
    n_a = 0;
    n_b = 0;
    scan_ptr = 0;
    terms_pending = 0;
    sat_flag = 0;
    for (int k = 0; k < ACC_N; k++) acc_mem[k] = '0;
    tx_idle = 26;
    rx_idle = 73;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(PHASE_N);
    tx_idle = 73;
    rx_idle = 26;
    test_random(PHASE_N);
    tx_idle = 0;
    rx_idle = 0;
    test_random(PHASE_N);
    @(posedge clk);
    in_valid <= 1'b0;
    guard = 0;
    while (pending_terms.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);
    if (pending_terms.size() != 0) begin
      errors++;
      $display("%0d result beats never arrived", pending_terms.size());
    end
    $display("sent %0d requests, checked %0d beats over %0d cycles", items_sent,
             beats_seen, cycles);
    $display("%0d terms read, %0d saturated beats, %0d store-full drops, %0d errors",
             terms_read, sat_beats, full_beats, errors);
    if (errors == 0) begin
      $display("tb_sparse_polynomial_add_sub_mul OK");
    end else begin
      $display("tb_sparse_polynomial_add_sub_mul NOT OK");
    end
    $finish;
  end

endmodule
